// ===== rtl/refresh_request_coalescer_defines.svh =====
// Assertion macros for the refresh request coalescer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef REFRESH_REQUEST_COALESCER_DEFINES_SVH
`define REFRESH_REQUEST_COALESCER_DEFINES_SVH

// Same-cycle implication, off during reset
`define RRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrc_pkg.sv =====
// Shared types, constants and helpers of the refresh request coalescer.
// No dependencies; imported by every module of the block.
package rrc_pkg;

  // Table geometry
  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int ACT_W  = 3;
  localparam int KEY_W  = 4;
  localparam int TIME_W = 48;
  localparam int OPS_W  = 8;
  localparam int WIN_W  = 16;

  // Largest loadable outstanding count
  localparam logic [32:0] COUNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;

  // Queue depths (powers of two)
  localparam int MIDQ_DEPTH = 2;
  localparam int MIDQ_PTR_W = 1;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;

  // Request action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_REQUEST     = 3'd0,
    ACT_REQUEST_NOW = 3'd1,
    ACT_MARK_FLIGHT = 3'd2,
    ACT_MARK_DONE   = 3'd3,
    ACT_POLL        = 3'd4
  } action_t;

  // Decoded operation, unknown actions map to OP_NOP
  typedef enum logic [2:0] {
    OP_REQUEST,
    OP_REQUEST_NOW,
    OP_FLIGHT,
    OP_DONE,
    OP_POLL,
    OP_NOP
  } op_t;

  // Result kinds
  localparam logic KIND_DUE    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_SUM
  } back_st_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key_index;
    logic [TIME_W-1:0] now_time;
    logic [OPS_W-1:0]  op_count;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  out_key;
    logic              in_flight;
    logic              is_pending;
    logic              found_due;
    logic [TIME_W-1:0] next_due;
    logic              last;
  } out_item_t;

  // Classified request as held between front and back
  typedef struct packed {
    op_t                   op;
    logic                  key_ok;
    logic [KEY_W-1:0]      key;
    logic [TIME_W-1:0]     now;
    logic [COUNT_BITS-1:0] cnt;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } fe_to_be_t;

  // now + window, saturating at the time maximum
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [WIN_W-1:0] w);
    logic [TIME_W:0] s;
    s = {1'b0, t} + (TIME_W+1)'(w);
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== rtl/refresh_request_coalescer.sv =====
// Refresh request coalescer. Requests enter through a queue-style port
// (push/full) and are decoded into a two-entry queue; a back-end sequencer
// then works on one request at a time against a 16-slot table and writes
// results into a four-entry result queue (empty/pop). A request, request-now,
// mark-in-flight or mark-done is taken from the queue in the idle state, then
// does one read-modify-write of the addressed slot, and returns one status
// result. A poll reads one slot per cycle through the single table read port
// while the result queue has space, then writes the summary, and returns one
// result per due idle slot plus a summary. A full result queue stalls the back
// end in its execute, scan and summary states. The window register is written
// through cfg_valid/cfg_ready, which is always ready.
`include "refresh_request_coalescer_defines.svh"

module refresh_request_coalescer
  import rrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // requests
  input  logic             push,
  input  in_item_t         in_data,
  output logic             full,
  // results
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_data,
  // window register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIN_W-1:0] cfg_data
);

  fe_to_be_t fe_q;
  logic      be_pop;
  logic      oq_space, oq_push;
  out_item_t oq_data;

  assign cfg_ready = 1'b1;

  // Front end: accept and classify
  rrc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .be_pop  (be_pop),
    .fe_q    (fe_q)
  );

  // Back end: slot table and sequencer
  rrc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .fe_q     (fe_q),
    .be_pop   (be_pop),
    .oq_space (oq_space),
    .oq_push  (oq_push),
    .oq_data  (oq_data)
  );

  // Result queue
  rrc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .oq_push  (oq_push),
    .oq_data  (oq_data),
    .oq_space (oq_space),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // Checks
  `RRC_ASSERT_NEXT(a_req_reaches_front, push && !full, fe_q.valid, "accepted request lost")
  `RRC_ASSERT_NOW(a_due_key_shape, !empty && out_data.kind == KIND_DUE, out_data.is_pending && !out_data.last, "bad due-key result")
  `RRC_ASSERT_NOW(a_status_last, !empty && out_data.kind == KIND_STATUS, out_data.last, "status or summary not last")

endmodule

// ===== rtl/rrc_front.sv =====
// Front end: accepts requests, decodes and range-checks them, and holds
// them in a short queue for the back end. Depends on rrc_pkg.
module rrc_front
  import rrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_data,
  output logic      full,
  input  logic      be_pop,
  output fe_to_be_t fe_q
);

  work_t                 mem_r [MIDQ_DEPTH];
  logic [MIDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [MIDQ_PTR_W:0]   cnt_r;
  work_t                 cls;
  logic                  wr_en, rd_en;

  // Decode the action, check the key, clamp the op count
  always_comb begin
    cls.key    = in_data.key_index;
    cls.now    = in_data.now_time;
    cls.key_ok = int'(in_data.key_index) < SLOTS;
    cls.cnt    = (33'(in_data.op_count) > COUNT_MAX_W) ? COUNT_BITS'(COUNT_MAX_W)
                                                        : COUNT_BITS'(in_data.op_count);
    unique case (in_data.action)
      ACT_REQUEST:     cls.op = OP_REQUEST;
      ACT_REQUEST_NOW: cls.op = OP_REQUEST_NOW;
      ACT_MARK_FLIGHT: cls.op = OP_FLIGHT;
      ACT_MARK_DONE:   cls.op = OP_DONE;
      ACT_POLL:        cls.op = OP_POLL;
      default:         cls.op = OP_NOP;
    endcase
  end

  assign full  = (cnt_r == (MIDQ_PTR_W+1)'(MIDQ_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = be_pop && (cnt_r != '0);

  assign fe_q.valid = (cnt_r != '0);
  assign fe_q.work  = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + MIDQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + MIDQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + (MIDQ_PTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - (MIDQ_PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/rrc_outq.sv =====
// Result queue between the back end and the result port.
// Depends on rrc_pkg.
module rrc_outq
  import rrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      oq_push,
  input  out_item_t oq_data,
  output logic      oq_space,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  out_item_t             mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_PTR_W:0]   cnt_r;
  logic                  wr_en, rd_en;

  assign oq_space = (cnt_r != (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign wr_en    = oq_push && oq_space;
  assign rd_en    = pop && !empty;
  assign out_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= oq_data;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + OUTQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + (OUTQ_PTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - (OUTQ_PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/rrc_back.sv =====
// Back end: slot table, window register and the sequencer that runs
// slot updates and poll scans. Depends on rrc_pkg.
module rrc_back
  import rrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr,
  input  logic [WIN_W-1:0] cfg_data,
  input  fe_to_be_t        fe_q,
  output logic             be_pop,
  input  logic             oq_space,
  output logic             oq_push,
  output out_item_t        oq_data
);

  // Slot table
  logic                  pend_r  [SLOTS];
  logic                  dirty_r [SLOTS];
  logic [COUNT_BITS-1:0] cnt_r   [SLOTS];
  logic [TIME_W-1:0]     due_r   [SLOTS];

  logic [WIN_W-1:0]  window_r;
  back_st_t          st_r, st_nxt;
  work_t             cur_r;
  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [TIME_W-1:0] early_r;

  logic [SLOT_W-1:0]     rd_idx;
  logic                  rd_pend, rd_dirty, busy;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [TIME_W-1:0]     rd_due, due_win;
  logic                  n_pend, n_dirty;
  logic [COUNT_BITS-1:0] n_cnt;
  logic [TIME_W-1:0]     n_due;
  logic                  hit, is_due, scan_end, slot_we;

  // One read port: scan index while polling, else the addressed slot
  assign rd_idx   = (st_r == BK_SCAN) ? idx_r
                  : (cur_r.key_ok ? SLOT_W'(cur_r.key) : '0);
  assign rd_pend  = pend_r[rd_idx];
  assign rd_dirty = dirty_r[rd_idx];
  assign rd_cnt   = cnt_r[rd_idx];
  assign rd_due   = due_r[rd_idx];
  assign busy     = (rd_cnt != '0);
  assign due_win  = sat_add(cur_r.now, window_r);

  // Scan terms
  assign hit      = rd_pend && !busy;
  assign is_due   = (cur_r.now >= rd_due);
  assign scan_end = (idx_r == SLOT_W'(SLOTS - 1));

  // Slot update
  always_comb begin
    n_pend  = rd_pend;
    n_dirty = rd_dirty;
    n_cnt   = rd_cnt;
    n_due   = rd_due;
    unique case (cur_r.op)
      OP_REQUEST: begin
        if (busy) begin
          n_dirty = 1'b1;
        end else if (!rd_pend) begin
          n_pend = 1'b1;
          n_due  = due_win;
        end
      end
      OP_REQUEST_NOW: begin
        if (busy) begin
          n_dirty = 1'b1;
        end else begin
          n_pend = 1'b1;
          n_due  = cur_r.now;
        end
      end
      OP_FLIGHT: begin
        n_pend = 1'b0;
        n_cnt  = cur_r.cnt;
      end
      OP_DONE: begin
        if (busy) begin
          n_cnt = rd_cnt - COUNT_BITS'(1);
          // last operation finished on a dirty slot: reschedule
          if (rd_cnt == COUNT_BITS'(1) && rd_dirty) begin
            n_dirty = 1'b0;
            n_pend  = 1'b1;
            n_due   = due_win;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (fe_q.valid) begin
          st_nxt = (fe_q.work.op == OP_POLL) ? BK_SCAN : BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (oq_space) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_SCAN: begin
        if (oq_space && scan_end) begin
          st_nxt = BK_SUM;
        end
      end
      BK_SUM: begin
        if (oq_space) begin
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Outputs: queue handshakes and result formatting
  always_comb begin
    be_pop  = 1'b0;
    oq_push = 1'b0;
    slot_we = 1'b0;
    oq_data = '0;
    unique case (st_r)
      BK_IDLE: begin
        be_pop = fe_q.valid;
      end
      BK_EXEC: begin
        oq_push            = oq_space;
        slot_we            = oq_space && cur_r.key_ok;
        oq_data.kind       = KIND_STATUS;
        oq_data.out_key    = cur_r.key;
        oq_data.in_flight  = cur_r.key_ok && (n_cnt != '0);
        oq_data.is_pending = cur_r.key_ok && n_pend;
        oq_data.last       = 1'b1;
      end
      BK_SCAN: begin
        oq_push            = oq_space && hit && is_due;
        oq_data.kind       = KIND_DUE;
        oq_data.out_key    = KEY_W'(idx_r);
        oq_data.is_pending = 1'b1;
      end
      BK_SUM: begin
        oq_push           = oq_space;
        oq_data.kind      = KIND_STATUS;
        oq_data.found_due = found_r;
        oq_data.next_due  = found_r ? early_r : '0;
        oq_data.last      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      window_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr) begin
        window_r <= cfg_data;
      end
    end
  end

  // Current request, scan index and running earliest due time
  always_ff @(posedge clk) begin
    if (be_pop) begin
      cur_r   <= fe_q.work;
      idx_r   <= '0;
      found_r <= 1'b0;
      early_r <= '0;
    end else if (st_r == BK_SCAN && oq_space) begin
      idx_r <= idx_r + SLOT_W'(1);
      if (hit && (!found_r || rd_due < early_r)) begin
        found_r <= 1'b1;
        early_r <= rd_due;
      end
    end
  end

  // Slot table write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        pend_r[i]  <= 1'b0;
        dirty_r[i] <= 1'b0;
        cnt_r[i]   <= '0;
        due_r[i]   <= '0;
      end
    end else if (slot_we) begin
      pend_r[rd_idx]  <= n_pend;
      dirty_r[rd_idx] <= n_dirty;
      cnt_r[rd_idx]   <= n_cnt;
      due_r[rd_idx]   <= n_due;
    end
  end

endmodule
